// File: rtl/gtg_pkg.sv
package gtg_pkg;

    // Field widths
    localparam int POS_W  = 32;
    localparam int ANG_W  = 16;
    localparam int THR_W  = 16;
    localparam int LIN_W  = 31;
    localparam int CFG_DW = 32;
    localparam int CFG_AW = 4;

    // Square root: one step per stage, 32 result bits
    localparam int SQRT_STEPS = 32;
    localparam int SQ_W       = 64;
    localparam int RES_W      = 64;

    // CORDIC datapath
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int CORDIC_SHIFT     = 20;
    localparam int ATAN_W           = 30;
    localparam int CX_W             = 56;
    localparam int Z_W              = 35;
    localparam int E_W              = 36;
    localparam int ANG_SHIFT        = 17;

    localparam longint PI_VAL     = 64'sd3373259426;
    localparam longint TWO_PI_VAL = 64'sd6746518852;

    localparam logic signed [Z_W-1:0] PI_Z      = Z_W'(PI_VAL);
    localparam logic signed [E_W-1:0] PI_E      = E_W'(PI_VAL);
    localparam logic signed [E_W-1:0] TWO_PI_E  = E_W'(TWO_PI_VAL);
    localparam logic signed [E_W-1:0] ROUND_E   = E_W'(64'sd1 <<< (ANG_SHIFT - 1));

    // Register map
    typedef enum logic [1:0] {
        REG_GOAL_X,
        REG_GOAL_Y,
        REG_ARRIVE_THR,
        REG_MAX_LINEAR
    } reg_idx_t;

    localparam logic [POS_W-1:0] GOAL_X_RST     = POS_W'(524288);
    localparam logic [POS_W-1:0] GOAL_Y_RST     = POS_W'(327680);
    localparam logic [THR_W-1:0] ARRIVE_THR_RST = THR_W'(7);
    localparam logic [LIN_W-1:0] MAX_LINEAR_RST = LIN_W'(65536);

    typedef struct packed {
        logic signed [POS_W-1:0] goal_x;
        logic signed [POS_W-1:0] goal_y;
        logic [THR_W-1:0]        arrive_threshold;
        logic [LIN_W-1:0]        max_linear;
    } cfg_t;

    typedef struct packed {
        logic signed [CX_W-1:0] x;
        logic signed [CX_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } cordic_t;

    // Payload carried through the iteration stages
    typedef struct packed {
        logic                    moving;
        logic [SQ_W-1:0]         rem;
        logic [RES_W-1:0]        res;
        cordic_t                 cor;
        logic signed [ANG_W-1:0] hd;
    } iter_t;

    // Arctangent of 2^-i in units of 2^-30 rad, truncated
    function automatic logic [ATAN_W-1:0] atan_q30(input logic [4:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:    v = 30'h3243F6A8;
            5'd1:    v = 30'h1DAC6705;
            5'd2:    v = 30'h0FADBAFC;
            5'd3:    v = 30'h07F56EA6;
            5'd4:    v = 30'h03FEAB76;
            5'd5:    v = 30'h01FFD55B;
            5'd6:    v = 30'h00FFFAAA;
            5'd7:    v = 30'h007FFF55;
            5'd8:    v = 30'h003FFFEA;
            5'd9:    v = 30'h001FFFFD;
            5'd10:   v = 30'h000FFFFF;
            5'd11:   v = 30'h0007FFFF;
            5'd12:   v = 30'h0003FFFF;
            5'd13:   v = 30'h0001FFFF;
            5'd14:   v = 30'h0000FFFF;
            5'd15:   v = 30'h00007FFF;
            5'd16:   v = 30'h00003FFF;
            5'd17:   v = 30'h00001FFF;
            5'd18:   v = 30'h00000FFF;
            5'd19:   v = 30'h000007FF;
            5'd20:   v = 30'h000003FF;
            5'd21:   v = 30'h000001FF;
            5'd22:   v = 30'h000000FF;
            5'd23:   v = 30'h0000007F;
            5'd24:   v = 30'h0000003F;
            5'd25:   v = 30'h0000001F;
            5'd26:   v = 30'h0000000F;
            5'd27:   v = 30'h00000008;
            5'd28:   v = 30'h00000004;
            5'd29:   v = 30'h00000002;
            5'd30:   v = 30'h00000001;
            default: v = 30'h00000000;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/gtg_if.sv
// Pose request channel
interface gtg_pose_if import gtg_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [ANG_W-1:0] heading;

    modport source (output valid, pos_x, pos_y, heading, input ready);
    modport sink   (input valid, pos_x, pos_y, heading, output ready);
endinterface

// Velocity command channel
interface gtg_cmd_if import gtg_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [LIN_W-1:0]        linear_cmd;
    logic signed [ANG_W-1:0] angular_cmd;
    logic                    at_goal;

    modport source (output valid, linear_cmd, angular_cmd, at_goal, input ready);
    modport sink   (input valid, linear_cmd, angular_cmd, at_goal, output ready);
endinterface

// File: rtl/gtg_regs.sv
module gtg_regs import gtg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.goal_x           <= GOAL_X_RST;
            cfg_reg.goal_y           <= GOAL_Y_RST;
            cfg_reg.arrive_threshold <= ARRIVE_THR_RST;
            cfg_reg.max_linear       <= MAX_LINEAR_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_GOAL_X:     cfg_reg.goal_x           <= pwdata;
                REG_GOAL_Y:     cfg_reg.goal_y           <= pwdata;
                REG_ARRIVE_THR: cfg_reg.arrive_threshold <= pwdata[THR_W-1:0];
                REG_MAX_LINEAR: cfg_reg.max_linear       <= pwdata[LIN_W-1:0];
                default:        ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        case (idx)
            REG_GOAL_X:     prdata = cfg_reg.goal_x;
            REG_GOAL_Y:     prdata = cfg_reg.goal_y;
            REG_ARRIVE_THR: prdata = {{(CFG_DW-THR_W){1'b0}}, cfg_reg.arrive_threshold};
            REG_MAX_LINEAR: prdata = {{(CFG_DW-LIN_W){1'b0}}, cfg_reg.max_linear};
            default:        prdata = '0;
        endcase
    end

endmodule

// File: rtl/gtg_front.sv
module gtg_front import gtg_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cfg_t                    cfg,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [POS_W-1:0] pos_x,
    input  logic signed [POS_W-1:0] pos_y,
    input  logic signed [ANG_W-1:0] heading,
    output logic                    out_valid,
    input  logic                    out_ready,
    output iter_t                   out_data
);

    function automatic logic [POS_W-1:0] sat_diff(input logic [POS_W:0] d);
        logic [POS_W-1:0] r;
        if (d[POS_W] != d[POS_W-1])
            r = d[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        else
            r = d[POS_W-1:0];
        return r;
    endfunction

    // Stage valid bits and ready chain
    logic v0_reg, v1_reg, v2_reg, v3_reg;
    logic r0, r1, r2, r3;

    assign r3       = !v3_reg || out_ready;
    assign r2       = !v2_reg || r3;
    assign r1       = !v1_reg || r2;
    assign r0       = !v0_reg || r1;
    assign in_ready = r0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (r0) v0_reg <= in_valid;
            if (r1) v1_reg <= v0_reg;
            if (r2) v2_reg <= v1_reg;
            if (r3) v3_reg <= v2_reg;
        end
    end

    // Stage 0: saturated goal minus position
    logic [POS_W:0]          diff_x, diff_y;
    logic [POS_W-1:0]        dx0_next, dy0_next;
    logic [POS_W-1:0]        dx0_reg, dy0_reg;
    logic signed [ANG_W-1:0] hd0_reg;

    assign diff_x   = {cfg.goal_x[POS_W-1], cfg.goal_x} - {pos_x[POS_W-1], pos_x};
    assign diff_y   = {cfg.goal_y[POS_W-1], cfg.goal_y} - {pos_y[POS_W-1], pos_y};
    assign dx0_next = sat_diff(diff_x);
    assign dy0_next = sat_diff(diff_y);

    always_ff @(posedge clk)
    begin
        if (r0 && in_valid)
        begin
            dx0_reg <= dx0_next;
            dy0_reg <= dy0_next;
            hd0_reg <= heading;
        end
    end

    // Stage 1: magnitudes and CORDIC pre-rotation into the right half plane
    logic [POS_W-1:0]        ax1_next, ay1_next, ax1_reg, ay1_reg;
    cordic_t                 cor1_next, cor1_reg;
    logic signed [CX_W-1:0]  cx_init, cy_init;
    logic signed [ANG_W-1:0] hd1_reg;

    always_comb
    begin
        ax1_next = dx0_reg[POS_W-1] ? (~dx0_reg + 1'b1) : dx0_reg;
        ay1_next = dy0_reg[POS_W-1] ? (~dy0_reg + 1'b1) : dy0_reg;
        cx_init  = {{(CX_W-POS_W){dx0_reg[POS_W-1]}}, dx0_reg} <<< CORDIC_SHIFT;
        cy_init  = {{(CX_W-POS_W){dy0_reg[POS_W-1]}}, dy0_reg} <<< CORDIC_SHIFT;
        if (dx0_reg[POS_W-1])
        begin
            cor1_next.x = -cx_init;
            cor1_next.y = -cy_init;
            cor1_next.z = dy0_reg[POS_W-1] ? -PI_Z : PI_Z;
        end
        else
        begin
            cor1_next.x = cx_init;
            cor1_next.y = cy_init;
            cor1_next.z = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (r1 && v0_reg)
        begin
            ax1_reg  <= ax1_next;
            ay1_reg  <= ay1_next;
            cor1_reg <= cor1_next;
            hd1_reg  <= hd0_reg;
        end
    end

    // Stage 2: squares and squared threshold
    logic [SQ_W-1:0]         sqx2_next, sqy2_next, sqx2_reg, sqy2_reg;
    logic [2*THR_W-1:0]      tt2_next, tt2_reg;
    cordic_t                 cor2_reg;
    logic signed [ANG_W-1:0] hd2_reg;

    assign sqx2_next = ax1_reg * ax1_reg;
    assign sqy2_next = ay1_reg * ay1_reg;
    assign tt2_next  = cfg.arrive_threshold * cfg.arrive_threshold;

    always_ff @(posedge clk)
    begin
        if (r2 && v1_reg)
        begin
            sqx2_reg <= sqx2_next;
            sqy2_reg <= sqy2_next;
            tt2_reg  <= tt2_next;
            cor2_reg <= cor1_reg;
            hd2_reg  <= hd1_reg;
        end
    end

    // Stage 3: squared distance and arrival test
    logic [SQ_W-1:0] sum3_next;
    iter_t           out3_next, out3_reg;

    always_comb
    begin
        sum3_next        = sqx2_reg + sqy2_reg;
        out3_next.moving = sum3_next > {{(SQ_W-2*THR_W){1'b0}}, tt2_reg};
        out3_next.rem    = sum3_next;
        out3_next.res    = '0;
        out3_next.cor    = cor2_reg;
        out3_next.hd     = hd2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (r3 && v2_reg)
            out3_reg <= out3_next;
    end

    assign out_valid = v3_reg;
    assign out_data  = out3_reg;

endmodule

// File: rtl/gtg_iter_stage.sv
module gtg_iter_stage import gtg_pkg::*;
#(
    parameter int STEP         = 0,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  iter_t in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output iter_t out_data
);

    localparam logic [RES_W-1:0] SQRT_BIT = RES_W'(1) << (RES_W - 2 - 2 * STEP);
    localparam logic [4:0]       STEP_IDX = 5'(STEP);
    localparam bit               DO_ROT   = (STEP < CORDIC_STEPS);

    logic                   valid_reg;
    iter_t                  data_reg, data_next;
    logic [SQ_W-1:0]        trial;
    logic signed [CX_W-1:0] cx, cy, xs, ys;
    logic signed [Z_W-1:0]  cz, atan_v;

    assign in_ready  = !valid_reg || out_ready;
    assign atan_v    = $signed({{(Z_W-ATAN_W){1'b0}}, atan_q30(STEP_IDX)});

    // One square-root digit and, while STEP < CORDIC_STEPS, one CORDIC micro-rotation
    always_comb
    begin
        data_next = in_data;
        trial     = in_data.rem;
        trial     = in_data.res + SQRT_BIT;
        if (in_data.rem >= trial)
        begin
            data_next.rem = in_data.rem - trial;
            data_next.res = (in_data.res >> 1) + SQRT_BIT;
        end
        else
        begin
            data_next.res = in_data.res >> 1;
        end

        cx = in_data.cor.x;
        cy = in_data.cor.y;
        cz = in_data.cor.z;
        xs = cx >>> STEP;
        ys = cy >>> STEP;
        if (DO_ROT)
        begin
            if (cy > 0)
            begin
                data_next.cor.x = cx + ys;
                data_next.cor.y = cy - xs;
                data_next.cor.z = cz + atan_v;
            end
            else
            begin
                data_next.cor.x = cx - ys;
                data_next.cor.y = cy + xs;
                data_next.cor.z = cz - atan_v;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: rtl/gtg_back.sv
module gtg_back import gtg_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cfg_t                    cfg,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  iter_t                   in_data,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [LIN_W-1:0]        linear_cmd,
    output logic signed [ANG_W-1:0] angular_cmd,
    output logic                    at_goal
);

    logic v0_reg, v1_reg;
    logic r0, r1;

    assign r1       = !v1_reg || out_ready;
    assign r0       = !v0_reg || r1;
    assign in_ready = r0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else
        begin
            if (r0) v0_reg <= in_valid;
            if (r1) v1_reg <= v0_reg;
        end
    end

    // Stage 0: speed clamp and raw heading error
    logic [2*THR_W-1:0]     dist_root;
    logic [LIN_W-1:0]       lin0_next, lin0_reg;
    logic signed [E_W-1:0]  err0_next, err0_reg;
    logic                   mov0_reg;

    always_comb
    begin
        dist_root = in_data.res[2*THR_W-1:0];
        if (dist_root > {{(2*THR_W-LIN_W){1'b0}}, cfg.max_linear})
            lin0_next = cfg.max_linear;
        else
            lin0_next = dist_root[LIN_W-1:0];
        err0_next = {{(E_W-Z_W){in_data.cor.z[Z_W-1]}}, in_data.cor.z}
                  - ({{(E_W-ANG_W){in_data.hd[ANG_W-1]}}, in_data.hd} <<< ANG_SHIFT);
    end

    always_ff @(posedge clk)
    begin
        if (r0 && in_valid)
        begin
            lin0_reg <= lin0_next;
            err0_reg <= err0_next;
            mov0_reg <= in_data.moving;
        end
    end

    // Stage 1: wrap into (-pi, pi], round to Q3.13, zero on arrival
    logic signed [E_W-1:0]   wrapped;
    logic signed [E_W-1:0]   ang_full;
    logic [LIN_W-1:0]        lin1_reg;
    logic signed [ANG_W-1:0] ang1_reg;
    logic                    goal1_reg;

    always_comb
    begin
        if (err0_reg > PI_E)
            wrapped = err0_reg - TWO_PI_E + ROUND_E;
        else if (err0_reg <= -PI_E)
            wrapped = err0_reg + TWO_PI_E + ROUND_E;
        else
            wrapped = err0_reg + ROUND_E;
        ang_full = wrapped >>> ANG_SHIFT;
    end

    always_ff @(posedge clk)
    begin
        if (r1 && v0_reg)
        begin
            if (mov0_reg)
            begin
                lin1_reg  <= lin0_reg;
                ang1_reg  <= ang_full[ANG_W-1:0];
                goal1_reg <= 1'b0;
            end
            else
            begin
                lin1_reg  <= '0;
                ang1_reg  <= '0;
                goal1_reg <= 1'b1;
            end
        end
    end

    assign out_valid   = v1_reg;
    assign linear_cmd  = lin1_reg;
    assign angular_cmd = ang1_reg;
    assign at_goal     = goal1_reg;

endmodule

// File: rtl/go_to_goal_velocity_controller_unit.sv
// Go-to-goal controller: 38 register stages (4 front, 32 square-root/CORDIC, 2 back).
// Throughput is one request per cycle while cmd.ready is high; each square-root digit and CORDIC
// rotation has its own stage, so nothing is shared between requests.
// Reset clears every stage valid bit and loads the register defaults.
module go_to_goal_velocity_controller_unit import gtg_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    gtg_pose_if.sink          pose,
    gtg_cmd_if.source         cmd,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready
);

    cfg_t              cfg;
    logic [SQRT_STEPS:0] iter_valid;
    logic [SQRT_STEPS:0] iter_ready;
    iter_t             iter_data [0:SQRT_STEPS];

    gtg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gtg_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (pose.valid),
        .in_ready  (pose.ready),
        .pos_x     (pose.pos_x),
        .pos_y     (pose.pos_y),
        .heading   (pose.heading),
        .out_valid (iter_valid[0]),
        .out_ready (iter_ready[0]),
        .out_data  (iter_data[0])
    );

    // Square-root digit and CORDIC rotation chain
    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_iter
        gtg_iter_stage #(
            .STEP         (k),
            .CORDIC_STEPS (CORDIC_STEPS)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (iter_valid[k]),
            .in_ready  (iter_ready[k]),
            .in_data   (iter_data[k]),
            .out_valid (iter_valid[k+1]),
            .out_ready (iter_ready[k+1]),
            .out_data  (iter_data[k+1])
        );
    end

    gtg_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (iter_valid[SQRT_STEPS]),
        .in_ready    (iter_ready[SQRT_STEPS]),
        .in_data     (iter_data[SQRT_STEPS]),
        .out_valid   (cmd.valid),
        .out_ready   (cmd.ready),
        .linear_cmd  (cmd.linear_cmd),
        .angular_cmd (cmd.angular_cmd),
        .at_goal     (cmd.at_goal)
    );

endmodule

// File: rtl/gtg_checker.sv
module gtg_checker import gtg_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic [LIN_W-1:0]        linear_cmd,
    input logic signed [ANG_W-1:0] angular_cmd,
    input logic                    at_goal
);

    // Arrival zeroes both commands
    a_goal_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && at_goal |-> linear_cmd == '0 && angular_cmd == '0)
        else $error("at_goal result with nonzero command");

    // Wrapped heading error stays within plus or minus pi
    a_ang_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !at_goal |-> angular_cmd >= -16'sd25736 && angular_cmd <= 16'sd25736)
        else $error("angular command outside wrap range");

    // Stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable({linear_cmd, angular_cmd, at_goal}))
        else $error("stalled result changed");

    // No result offered during reset
    a_reset: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result valid during reset");

endmodule

bind go_to_goal_velocity_controller_unit gtg_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (cmd.valid),
    .out_ready   (cmd.ready),
    .linear_cmd  (cmd.linear_cmd),
    .angular_cmd (cmd.angular_cmd),
    .at_goal     (cmd.at_goal)
);
